/* rtl/core/vt4_pkg.sv */
package vt4_pkg;

	// default fraction bits of the fixed-point format
	localparam int FRAC_BITS_DEF = 16;

	// matrix registers, two per row
	localparam int NUM_REGS = 8;

	// divider stages: overflow check plus one stage per quotient bit
	localparam int QUO_BITS = 33;
	localparam int DIV_LAT  = QUO_BITS + 1;

	// operation codes carried in tuser
	localparam logic [1:0] FUNC_DIR      = 2'd0;
	localparam logic [1:0] FUNC_POINT    = 2'd1;
	localparam logic [1:0] FUNC_PROJ     = 2'd2;
	localparam logic [1:0] FUNC_PROJ_ALT = 2'd3;

	// side information that travels beside the divider lanes
	typedef struct packed {
		logic             proj;
		logic             wz;
		logic [2:0]       neg;
		logic [2:0][31:0] np_res;
		logic             np_sat;
	} sb_t;

endpackage

/* rtl/core/vertex_transform_4x4.sv */
// Channel | Dir | tdata (low bit up)        | tuser (low bit up)
// s_*     | in  | in_x, in_y, in_z (32 each) | func (2)
// m_*     | out | out_x, out_y, out_z        | saturated, w_zero
// apb     | in  | 64-bit matrix registers at byte address 8*i
//
// One request enters every cycle unless stalled; it runs through stages
// 1-3, a one-bit-per-stage divider (33 bits plus a check) and output reg.
// Reset (arst_n low) clears all valid bits and loads the identity matrix.
// A stall on m_tready freezes the whole pipe; s_tready falls with it.
module vertex_transform_4x4 import vt4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // in_x, in_y, in_z
	input  logic [1:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // out_x, out_y, out_z
	output logic [1:0]   m_tuser   // saturated, w_zero
);

	localparam int CW = 67 - FRAC_BITS;
	localparam logic [63:0] ONE64 = 64'(1) << FRAC_BITS;
	localparam logic signed [CW-1:0] MAXV = CW'(64'sd2147483647);
	localparam logic signed [CW-1:0] MINV = CW'(-64'sd2147483648);

	logic [63:0] regs_q [NUM_REGS];
	logic signed [31:0] m [4][4];
	logic en;

	// matrix registers, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{ONE64, 64'd0, ONE64 << 32, 64'd0, 64'd0, ONE64, 64'd0, ONE64 << 32};
		end else if (psel && penable && pwrite) begin
			regs_q[paddr[5:3]] <= pwdata;
		end
	end

	assign prdata = regs_q[paddr[5:3]];
	assign pready = 1'b1;

	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign m[r][c] = regs_q[2*r + c/2][32*(c%2) +: 32];
		end
	end

	// advance the pipe whenever the output register is free or taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: products
	logic               v_s1;
	logic [1:0]         func_s1;
	logic signed [63:0] prod_s1 [3][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= s_tuser;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= $signed(s_tdata[32*r +: 32]) * m[r][c];
				end
			end
		end
	end

	// stage 2: column sums, floor shift, translation (not for directions)
	logic                 v_s2;
	logic [1:0]           func_s2;
	logic signed [CW-1:0] col_s2 [4];
	logic signed [65:0]   sum [4];
	logic signed [65:0]   shf [4];
	logic signed [CW-1:0] col_d [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c] = 66'(prod_s1[0][c]) + 66'(prod_s1[1][c]) + 66'(prod_s1[2][c]);
			shf[c] = sum[c] >>> FRAC_BITS;
			col_d[c] = CW'(shf[c]);
			if (func_s1 != FUNC_DIR) col_d[c] = col_d[c] + CW'(m[3][c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			col_s2  <= col_d;
		end
	end

	// stage 3: saturate direct results, take magnitudes for the divider
	logic          v_s3;
	sb_t           sb_s3;
	sb_t           sb_d;
	logic [CW-1:0] n_s3 [3];
	logic [CW-1:0] d_s3;
	logic [CW-1:0] n_d  [3];

	always_comb begin
		sb_d.proj   = func_s2 inside {FUNC_PROJ, FUNC_PROJ_ALT};
		sb_d.wz     = sb_d.proj && (col_s2[3] == '0);
		sb_d.np_sat = 1'b0;
		for (int c = 0; c < 3; c++) begin
			sb_d.neg[c] = col_s2[c][CW-1] ^ col_s2[3][CW-1];
			n_d[c] = col_s2[c][CW-1] ? CW'(-col_s2[c]) : CW'(col_s2[c]);
			if (col_s2[c] > MAXV) begin
				sb_d.np_res[c] = 32'h7FFF_FFFF;
				sb_d.np_sat    = 1'b1;
			end else if (col_s2[c] < MINV) begin
				sb_d.np_res[c] = 32'h8000_0000;
				sb_d.np_sat    = 1'b1;
			end else begin
				sb_d.np_res[c] = col_s2[c][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= sb_d;
			n_s3  <= n_d;
			d_s3  <= col_s2[3][CW-1] ? CW'(-col_s2[3]) : CW'(col_s2[3]);
		end
	end

	// divider lanes
	logic [QUO_BITS-1:0] quo [3];
	logic                ovf [3];

	for (genvar c = 0; c < 3; c++) begin : g_div
		vt4_div #(.MW(CW), .F(FRAC_BITS)) u_div (
			.clk (clk),
			.en  (en),
			.n   (n_s3[c]),
			.d   (d_s3),
			.quo (quo[c]),
			.ovf (ovf[c])
		);
	end

	// side information and valid bits keep pace with the divider
	logic vd_s [DIV_LAT];
	sb_t  sbd_s [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) vd_s[k] <= 1'b0;
		end else if (en) begin
			vd_s[0] <= v_s3;
			for (int k = 1; k < DIV_LAT; k++) vd_s[k] <= vd_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sbd_s[0] <= sb_s3;
			for (int k = 1; k < DIV_LAT; k++) sbd_s[k] <= sbd_s[k-1];
		end
	end

	// final select: sign, saturation, zero w
	sb_t              sbo;
	logic [2:0][31:0] res_d;
	logic             sat_d;
	logic             over;

	assign sbo = sbd_s[DIV_LAT-1];

	always_comb begin
		sat_d = 1'b0;
		res_d = '0;
		over  = 1'b0;
		if (!sbo.proj) begin
			res_d = sbo.np_res;
			sat_d = sbo.np_sat;
		end else if (!sbo.wz) begin
			for (int c = 0; c < 3; c++) begin
				if (sbo.neg[c]) begin
					over = ovf[c] || (quo[c] > 33'h0_8000_0000);
					res_d[c] = over ? 32'h8000_0000 : 32'(33'(0) - quo[c]);
				end else begin
					over = ovf[c] || (quo[c] > 33'h0_7FFF_FFFF);
					res_d[c] = over ? 32'h7FFF_FFFF : quo[c][31:0];
				end
				sat_d = sat_d | over;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= vd_s[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res_d;
			m_tuser <= {sbo.wz, sat_d};
		end
	end

endmodule

/* rtl/core/vt4_div.sv */
// Pipelined restoring divider: quo = floor((n << F) / d), one quotient bit
// per stage; ovf flags a quotient of 2^QUO_BITS or more.
module vt4_div import vt4_pkg::*; #(
	parameter int MW = 51,
	parameter int F  = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [MW-1:0]       n,
	input  logic [MW-1:0]       d,
	output logic [QUO_BITS-1:0] quo,
	output logic                ovf
);

	localparam int RW   = MW + F;
	localparam int CMPW = MW + QUO_BITS + 1;

	logic [RW-1:0]       rem_s [DIV_LAT];
	logic [MW-1:0]       dv_s  [DIV_LAT];
	logic [QUO_BITS-1:0] qt_s  [DIV_LAT];
	logic                ov_s  [DIV_LAT];

	// load the shifted numerator and check for overflow up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {n, F'(0)};
			dv_s[0]  <= d;
			qt_s[0]  <= '0;
			ov_s[0]  <= CMPW'({n, F'(0)}) >= (CMPW'(d) << QUO_BITS);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
		localparam int SH = QUO_BITS - k;
		logic [CMPW-1:0] cand;
		logic [CMPW-1:0] dsh;
		logic            ge;

		assign cand = CMPW'(rem_s[k-1]);
		assign dsh  = CMPW'(dv_s[k-1]) << SH;
		assign ge   = cand >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RW'(cand - dsh) : rem_s[k-1];
				dv_s[k]  <= dv_s[k-1];
				qt_s[k]  <= qt_s[k-1] | (QUO_BITS'(ge) << SH);
				ov_s[k]  <= ov_s[k-1];
			end
		end
	end

	assign quo = qt_s[DIV_LAT-1];
	assign ovf = ov_s[DIV_LAT-1];

endmodule

/* rtl/core/vt4_chk.sv */
module vt4_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// zero w gives zero coordinates and no saturation
	a_wz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
		else $error("zero w result not cleared");

	// accept whenever the output stage is empty or draining
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with free output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind vertex_transform_4x4 vt4_chk u_chk (.*);
